/* rtl/assert_macros.svh */
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define EMFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define EMFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define EMFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define EMFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/emfc_pkg.sv */
`default_nettype none
package emfc_pkg;

  localparam logic [63:0] CANON_NAN = 64'h7FF8000000000000;

  // stages of one multiply or add: front, sum, lead count, shift, round
  localparam int OP_LAT = 5;
  localparam int DIV_QBITS = 56;
  localparam int DIV_STEPS = 2;
  localparam int DIV_ITERS = DIV_QBITS / DIV_STEPS;
  // front, normalize, then one stage per iteration
  localparam int DIV_CORE_LAT = 2 + DIV_ITERS;
  localparam int DIV_LAT = DIV_CORE_LAT + 3;

  typedef enum logic [1:0] {CLS_NUM, CLS_ZERO, CLS_INF, CLS_NAN} cls_t;

  typedef struct packed {
    cls_t        cls;
    logic        sgn;
    logic [10:0] ex;
    logic [52:0] man;
  } unpk_t;

  // value = mag * 2^(ex - 1128)
  typedef struct packed {
    cls_t               cls;
    logic               sgn;
    logic signed [13:0] ex;
    logic [105:0]       mag;
  } raw_t;

  typedef struct packed {
    cls_t               cls;
    logic               sgn;
    logic signed [13:0] ex;
    logic [51:0]        hh;
    logic [52:0]        hl;
    logic [52:0]        lh;
    logic [53:0]        ll;
  } mpp_t;

  typedef struct packed {
    cls_t               cls;
    logic               sgn;
    logic               sub;
    logic signed [13:0] ex;
    logic [105:0]       big;
    logic [105:0]       sml;
  } aln_t;

  typedef struct packed {
    raw_t       raw;
    logic [6:0] lz;
  } nrm_t;

  // value = 1.m[54:0] * 2^(ex - 1023), sticky in m[0]
  typedef struct packed {
    cls_t               cls;
    logic               sgn;
    logic signed [13:0] ex;
    logic [55:0]        m;
  } rnd_t;

  function automatic unpk_t unpack(input logic [63:0] x);
    unpk_t u;
    u.sgn = x[63];
    u.ex  = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
    u.man = {(x[62:52] != 11'd0), x[51:0]};
    if (x[62:52] == 11'h7FF) begin
      u.cls = (x[51:0] != 52'd0) ? CLS_NAN : CLS_INF;
    end else if (x[62:0] == 63'd0) begin
      u.cls = CLS_ZERO;
    end else begin
      u.cls = CLS_NUM;
    end
    return u;
  endfunction

  function automatic mpp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
    unpk_t ua;
    unpk_t ub;
    mpp_t  p;
    ua = unpack(a);
    ub = unpack(b);
    p.sgn = ua.sgn ^ ub.sgn;
    if (ua.cls == CLS_NAN || ub.cls == CLS_NAN ||
        (ua.cls == CLS_INF && ub.cls == CLS_ZERO) ||
        (ua.cls == CLS_ZERO && ub.cls == CLS_INF)) begin
      p.cls = CLS_NAN;
    end else if (ua.cls == CLS_INF || ub.cls == CLS_INF) begin
      p.cls = CLS_INF;
    end else if (ua.cls == CLS_ZERO || ub.cls == CLS_ZERO) begin
      p.cls = CLS_ZERO;
    end else begin
      p.cls = CLS_NUM;
    end
    p.ex = $signed({3'b000, ua.ex}) + $signed({3'b000, ub.ex}) - 14'sd1022;
    p.hh = ua.man[52:27] * ub.man[52:27];
    p.hl = ua.man[52:27] * ub.man[26:0];
    p.lh = ua.man[26:0] * ub.man[52:27];
    p.ll = ua.man[26:0] * ub.man[26:0];
    return p;
  endfunction

  function automatic raw_t mul_sum(input mpp_t p);
    raw_t r;
    r.cls = p.cls;
    r.sgn = p.sgn;
    r.ex  = p.ex;
    r.mag = ({54'd0, p.hh} << 54) + ({53'd0, p.hl} << 27) + ({53'd0, p.lh} << 27) +
            {52'd0, p.ll};
    return r;
  endfunction

  function automatic aln_t add_align(input logic [63:0] a, input logic [63:0] b);
    unpk_t        ua;
    unpk_t        ub;
    unpk_t        ubig;
    unpk_t        usml;
    logic [10:0]  d;
    logic [105:0] sml0;
    logic [105:0] lost;
    aln_t         al;
    ua = unpack(a);
    ub = unpack(b);
    if (b[62:0] > a[62:0]) begin
      ubig = ub;
      usml = ua;
    end else begin
      ubig = ua;
      usml = ub;
    end
    al.sub = ua.sgn ^ ub.sgn;
    al.sgn = ubig.sgn;
    al.ex  = $signed({3'b000, ubig.ex}) + 14'sd1;
    d      = ubig.ex - usml.ex;
    al.big = {1'b0, ubig.man, 52'd0};
    sml0   = {1'b0, usml.man, 52'd0};
    lost   = sml0 & ~({106{1'b1}} << d);
    al.sml = (sml0 >> d) | {105'd0, (lost != 106'd0)};
    if (ua.cls == CLS_NAN || ub.cls == CLS_NAN ||
        (ua.cls == CLS_INF && ub.cls == CLS_INF && al.sub)) begin
      al.cls = CLS_NAN;
    end else if (ua.cls == CLS_INF || ub.cls == CLS_INF) begin
      al.cls = CLS_INF;
    end else begin
      al.cls = CLS_NUM;
    end
    return al;
  endfunction

  function automatic raw_t add_sum(input aln_t al);
    raw_t r;
    r.cls = al.cls;
    r.sgn = al.sgn;
    r.ex  = al.ex;
    r.mag = al.sub ? (al.big - al.sml) : (al.big + al.sml);
    // exact cancellation rounds to +0, like signs keep theirs
    if (al.cls == CLS_NUM && r.mag == 106'd0) begin
      r.cls = CLS_ZERO;
      r.sgn = al.sub ? 1'b0 : al.sgn;
    end
    return r;
  endfunction

  function automatic nrm_t norm_lz(input raw_t r);
    nrm_t n;
    n.raw = r;
    n.lz  = 7'd0;
    for (int i = 0; i < 106; i++) begin
      if (r.mag[i]) n.lz = 7'(105 - i);
    end
    return n;
  endfunction

  function automatic rnd_t norm_shift(input nrm_t n);
    logic [105:0] m;
    rnd_t         x;
    m     = n.raw.mag << n.lz;
    x.cls = n.raw.cls;
    x.sgn = n.raw.sgn;
    x.ex  = n.raw.ex - $signed({7'd0, n.lz});
    x.m   = {m[105:51], m[50] | (m[49:0] != 50'd0)};
    return x;
  endfunction

  function automatic logic [63:0] round_pack(input rnd_t x);
    logic signed [13:0] ee;
    logic signed [13:0] eo;
    logic [13:0]        shamt;
    logic [55:0]        sh;
    logic [55:0]        lost;
    logic               up;
    logic [53:0]        sum;
    logic [51:0]        frac;
    logic [63:0]        res;
    if (x.ex < 14'sd1) begin
      ee    = 14'sd1;
      shamt = 14'(14'sd1 - x.ex);
    end else begin
      ee    = x.ex;
      shamt = 14'd0;
    end
    lost = x.m & ~({56{1'b1}} << shamt);
    sh   = (x.m >> shamt) | {55'd0, (lost != 56'd0)};
    up   = sh[2] & (sh[3] | sh[1] | sh[0]);
    sum  = {1'b0, sh[55:3]} + {53'd0, up};
    if (sum[53]) begin
      eo   = ee + 14'sd1;
      frac = sum[52:1];
    end else begin
      eo   = sum[52] ? ee : 14'sd0;
      frac = sum[51:0];
    end
    case (x.cls)
      CLS_NAN:  res = CANON_NAN;
      CLS_INF:  res = {x.sgn, 11'h7FF, 52'd0};
      CLS_ZERO: res = {x.sgn, 63'd0};
      default: begin
        if (eo >= 14'sd2047) res = {x.sgn, 11'h7FF, 52'd0};
        else res = {x.sgn, eo[10:0], frac};
      end
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

/* rtl/ambipolar_emf_correction_top.sv */
// throughput: one edge per cycle; the whole pipeline advances together and
//   holds while a finished result waits, so no beat is lost or repeated
// the quotient takes 28 stages of a two-bit restoring divider
// reset: synchronous active-low rst_n clears all valid bits and tiny_bias
`default_nettype none
`include "assert_macros.svh"
module ambipolar_emf_correction_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [63:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_eta_edge,
  input  wire logic [63:0] in_cur_par,
  input  wire logic [63:0] in_cur_t1,
  input  wire logic [63:0] in_cur_t2,
  input  wire logic [63:0] in_fld_par,
  input  wire logic [63:0] in_fld_t1,
  input  wire logic [63:0] in_fld_t2,
  input  wire logic [63:0] in_emf_old,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_emf_new
);

  localparam int P1 = emfc_pkg::OP_LAT;
  localparam int P2 = P1 + emfc_pkg::OP_LAT;
  localparam int P3 = P2 + emfc_pkg::OP_LAT;
  localparam int P4 = P3 + emfc_pkg::OP_LAT;
  localparam int P5 = P4 + emfc_pkg::DIV_LAT;
  localparam int P6 = P5 + emfc_pkg::OP_LAT;
  localparam int P7 = P6 + emfc_pkg::OP_LAT;
  localparam int P8 = P7 + emfc_pkg::OP_LAT;
  localparam int DIV_OUT = P4 + emfc_pkg::DIV_CORE_LAT;

  logic        adv;
  logic [P8:1] vld_r;
  logic [63:0] tiny_bias_r;

  logic [63:0] bp_dly_r  [1:P3];
  logic [63:0] jp_dly_r  [1:P5];
  logic [63:0] eta_dly_r [1:P6];
  logic [63:0] emf_dly_r [1:P7];

  // products: Bp^2, B1^2, B2^2, Jp*Bp, J1*B1, J2*B2
  emfc_pkg::mpp_t mpp1_r [0:5];
  emfc_pkg::raw_t raw1_r [0:5];
  emfc_pkg::nrm_t nrm1_r [0:5];
  emfc_pkg::rnd_t rnd1_r [0:5];
  logic [63:0]    prd1_r [0:5];

  // first sums, lane 0 field and lane 1 current-dot-field
  emfc_pkg::aln_t aln2_r [0:1];
  emfc_pkg::raw_t raw2_r [0:1];
  emfc_pkg::nrm_t nrm2_r [0:1];
  emfc_pkg::rnd_t rnd2_r [0:1];
  logic [63:0]    sum2_r [0:1];

  // lane 0 bsq with bias, lane 1 numerator jdb*Bp
  emfc_pkg::aln_t aln4_r;
  emfc_pkg::mpp_t mpp4_r;
  emfc_pkg::raw_t raw4_r [0:1];
  emfc_pkg::nrm_t nrm4_r [0:1];
  emfc_pkg::rnd_t rnd4_r [0:1];
  logic [63:0]    res4_r [0:1];

  emfc_pkg::raw_t quo;
  emfc_pkg::nrm_t nrm5_r;
  emfc_pkg::rnd_t rnd5_r;
  logic [63:0]    par_r;

  emfc_pkg::aln_t aln6_r;
  emfc_pkg::raw_t raw6_r;
  emfc_pkg::nrm_t nrm6_r;
  emfc_pkg::rnd_t rnd6_r;
  logic [63:0]    dif_r;

  emfc_pkg::mpp_t mpp7_r;
  emfc_pkg::raw_t raw7_r;
  emfc_pkg::nrm_t nrm7_r;
  emfc_pkg::rnd_t rnd7_r;
  logic [63:0]    inc_r;

  emfc_pkg::aln_t aln8_r;
  emfc_pkg::raw_t raw8_r;
  emfc_pkg::nrm_t nrm8_r;
  emfc_pkg::rnd_t rnd8_r;
  logic [63:0]    res_r;

  // every stage moves on the same beat; a held result freezes the line
  assign adv       = !vld_r[P8] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[P8];
  assign out_emf_new = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      tiny_bias_r <= 64'd0;
    end else begin
      if (cfg_wr_en) tiny_bias_r <= cfg_wr_data;
      if (adv) vld_r <= {vld_r[P8-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bp_dly_r[1]  <= in_fld_par;
      jp_dly_r[1]  <= in_cur_par;
      eta_dly_r[1] <= in_eta_edge;
      emf_dly_r[1] <= in_emf_old;
      for (int k = 2; k <= P3; k++) bp_dly_r[k] <= bp_dly_r[k-1];
      for (int k = 2; k <= P5; k++) jp_dly_r[k] <= jp_dly_r[k-1];
      for (int k = 2; k <= P6; k++) eta_dly_r[k] <= eta_dly_r[k-1];
      for (int k = 2; k <= P7; k++) emf_dly_r[k] <= emf_dly_r[k-1];

      mpp1_r[0] <= emfc_pkg::mul_pp(in_fld_par, in_fld_par);
      mpp1_r[1] <= emfc_pkg::mul_pp(in_fld_t1, in_fld_t1);
      mpp1_r[2] <= emfc_pkg::mul_pp(in_fld_t2, in_fld_t2);
      mpp1_r[3] <= emfc_pkg::mul_pp(in_cur_par, in_fld_par);
      mpp1_r[4] <= emfc_pkg::mul_pp(in_cur_t1, in_fld_t1);
      mpp1_r[5] <= emfc_pkg::mul_pp(in_cur_t2, in_fld_t2);
      for (int i = 0; i < 6; i++) begin
        raw1_r[i] <= emfc_pkg::mul_sum(mpp1_r[i]);
        nrm1_r[i] <= emfc_pkg::norm_lz(raw1_r[i]);
        rnd1_r[i] <= emfc_pkg::norm_shift(nrm1_r[i]);
        prd1_r[i] <= emfc_pkg::round_pack(rnd1_r[i]);
      end

      aln2_r[0] <= emfc_pkg::add_align(prd1_r[0], prd1_r[1]);
      aln2_r[1] <= emfc_pkg::add_align(prd1_r[3], prd1_r[4]);
      for (int i = 0; i < 2; i++) begin
        raw2_r[i] <= emfc_pkg::add_sum(aln2_r[i]);
        nrm2_r[i] <= emfc_pkg::norm_lz(raw2_r[i]);
        rnd2_r[i] <= emfc_pkg::norm_shift(nrm2_r[i]);
        sum2_r[i] <= emfc_pkg::round_pack(rnd2_r[i]);
      end
    end
  end

  // the third products wait one add in a delay line so they meet the
  // running sums
  logic [63:0] prd_hold_r [0:1][1:emfc_pkg::OP_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      prd_hold_r[0][1] <= prd1_r[2];
      prd_hold_r[1][1] <= prd1_r[5];
      for (int k = 2; k <= emfc_pkg::OP_LAT; k++) begin
        prd_hold_r[0][k] <= prd_hold_r[0][k-1];
        prd_hold_r[1][k] <= prd_hold_r[1][k-1];
      end
    end
  end

  // third-stage sums take the held copies
  logic [63:0] b2sq_d;
  logic [63:0] j2b2_d;
  assign b2sq_d = prd_hold_r[0][emfc_pkg::OP_LAT];
  assign j2b2_d = prd_hold_r[1][emfc_pkg::OP_LAT];

  emfc_pkg::aln_t aln3f_r [0:1];
  emfc_pkg::raw_t raw3f_r [0:1];
  emfc_pkg::nrm_t nrm3f_r [0:1];
  emfc_pkg::rnd_t rnd3f_r [0:1];
  logic [63:0]    sum3f_r [0:1];

  always_ff @(posedge clk) begin
    if (adv) begin
      aln3f_r[0] <= emfc_pkg::add_align(sum2_r[0], b2sq_d);
      aln3f_r[1] <= emfc_pkg::add_align(sum2_r[1], j2b2_d);
      for (int i = 0; i < 2; i++) begin
        raw3f_r[i] <= emfc_pkg::add_sum(aln3f_r[i]);
        nrm3f_r[i] <= emfc_pkg::norm_lz(raw3f_r[i]);
        rnd3f_r[i] <= emfc_pkg::norm_shift(nrm3f_r[i]);
        sum3f_r[i] <= emfc_pkg::round_pack(rnd3f_r[i]);
      end

      aln4_r <= emfc_pkg::add_align(sum3f_r[0], tiny_bias_r);
      mpp4_r <= emfc_pkg::mul_pp(sum3f_r[1], bp_dly_r[P3]);
      raw4_r[0] <= emfc_pkg::add_sum(aln4_r);
      raw4_r[1] <= emfc_pkg::mul_sum(mpp4_r);
      for (int i = 0; i < 2; i++) begin
        nrm4_r[i] <= emfc_pkg::norm_lz(raw4_r[i]);
        rnd4_r[i] <= emfc_pkg::norm_shift(nrm4_r[i]);
        res4_r[i] <= emfc_pkg::round_pack(rnd4_r[i]);
      end

      nrm5_r <= emfc_pkg::norm_lz(quo);
      rnd5_r <= emfc_pkg::norm_shift(nrm5_r);
      par_r  <= emfc_pkg::round_pack(rnd5_r);

      // subtract by flipping the sign of the parallel part
      aln6_r <= emfc_pkg::add_align(jp_dly_r[P5], {~par_r[63], par_r[62:0]});
      raw6_r <= emfc_pkg::add_sum(aln6_r);
      nrm6_r <= emfc_pkg::norm_lz(raw6_r);
      rnd6_r <= emfc_pkg::norm_shift(nrm6_r);
      dif_r  <= emfc_pkg::round_pack(rnd6_r);

      mpp7_r <= emfc_pkg::mul_pp(eta_dly_r[P6], dif_r);
      raw7_r <= emfc_pkg::mul_sum(mpp7_r);
      nrm7_r <= emfc_pkg::norm_lz(raw7_r);
      rnd7_r <= emfc_pkg::norm_shift(nrm7_r);
      inc_r  <= emfc_pkg::round_pack(rnd7_r);

      aln8_r <= emfc_pkg::add_align(emf_dly_r[P7], inc_r);
      raw8_r <= emfc_pkg::add_sum(aln8_r);
      nrm8_r <= emfc_pkg::norm_lz(raw8_r);
      rnd8_r <= emfc_pkg::norm_shift(nrm8_r);
      res_r  <= emfc_pkg::round_pack(rnd8_r);
    end
  end

  emfc_div u_div (
    .clk (clk),
    .adv (adv),
    .num (res4_r[1]),
    .den (res4_r[0]),
    .quo (quo)
  );

  `EMFC_ASSERT_NXT(a_stall_hold, clk, rst_n, !in_ready, $stable(vld_r), "pipeline moved on stall")
  `EMFC_ASSERT_IMP(a_nan_canon, clk, rst_n, out_valid && out_emf_new[62:52] == 11'h7FF && out_emf_new[51:0] != 52'd0, out_emf_new == emfc_pkg::CANON_NAN, "non-canonical nan")
  `EMFC_ASSERT_IMP(a_quo_norm, clk, rst_n, vld_r[DIV_OUT] && quo.cls == emfc_pkg::CLS_NUM, quo.mag[105:104] != 2'b00, "quotient not normalized")

endmodule
`default_nettype wire

/* rtl/emfc_div.sv */
`default_nettype none
module emfc_div (
  input  wire logic          clk,
  input  wire logic          adv,
  input  wire logic [63:0]   num,
  input  wire logic [63:0]   den,
  output emfc_pkg::raw_t     quo
);

  typedef struct packed {
    emfc_pkg::cls_t cls;
    logic           sgn;
    logic [10:0]    ea;
    logic [10:0]    eb;
    logic [52:0]    ma;
    logic [52:0]    mb;
    logic [5:0]     la;
    logic [5:0]     lb;
  } dfr_t;

  typedef struct packed {
    emfc_pkg::cls_t     cls;
    logic               sgn;
    logic signed [13:0] ex;
    logic [52:0]        mb;
    logic [53:0]        r;
    logic [55:0]        q;
  } dst_t;

  function automatic logic [5:0] lz53(input logic [52:0] m);
    logic [5:0] z;
    z = 6'd0;
    for (int i = 0; i < 53; i++) begin
      if (m[i]) z = 6'(52 - i);
    end
    return z;
  endfunction

  function automatic dfr_t div_front(input logic [63:0] n, input logic [63:0] d);
    emfc_pkg::unpk_t un;
    emfc_pkg::unpk_t ud;
    dfr_t            f;
    un = emfc_pkg::unpack(n);
    ud = emfc_pkg::unpack(d);
    f.sgn = un.sgn ^ ud.sgn;
    if (ud.cls == emfc_pkg::CLS_ZERO) begin
      f.cls = (un.cls == emfc_pkg::CLS_NAN || un.cls == emfc_pkg::CLS_ZERO) ?
              emfc_pkg::CLS_NAN : emfc_pkg::CLS_INF;
    end else if (un.cls == emfc_pkg::CLS_NAN || ud.cls == emfc_pkg::CLS_NAN ||
                 (un.cls == emfc_pkg::CLS_INF && ud.cls == emfc_pkg::CLS_INF)) begin
      f.cls = emfc_pkg::CLS_NAN;
    end else if (un.cls == emfc_pkg::CLS_INF) begin
      f.cls = emfc_pkg::CLS_INF;
    end else if (ud.cls == emfc_pkg::CLS_INF || un.cls == emfc_pkg::CLS_ZERO) begin
      f.cls = emfc_pkg::CLS_ZERO;
    end else begin
      f.cls = emfc_pkg::CLS_NUM;
    end
    f.ea = un.ex;
    f.eb = ud.ex;
    f.ma = un.man;
    f.mb = ud.man;
    f.la = lz53(un.man);
    f.lb = lz53(ud.man);
    return f;
  endfunction

  function automatic dst_t div_norm(input dfr_t f);
    dst_t s;
    s.cls = f.cls;
    s.sgn = f.sgn;
    s.ex  = ($signed({3'b000, f.ea}) - $signed({8'd0, f.la})) -
            ($signed({3'b000, f.eb}) - $signed({8'd0, f.lb})) + 14'sd1023;
    s.mb  = f.mb << f.lb;
    s.r   = {1'b0, f.ma << f.la};
    s.q   = 56'd0;
    return s;
  endfunction

  // restoring steps, partial remainder stays below twice the divisor
  function automatic dst_t div_step(input dst_t s);
    dst_t t;
    t = s;
    for (int j = 0; j < emfc_pkg::DIV_STEPS; j++) begin
      if (t.r >= {1'b0, t.mb}) begin
        t.r = t.r - {1'b0, t.mb};
        t.q = {t.q[54:0], 1'b1};
      end else begin
        t.q = {t.q[54:0], 1'b0};
      end
      t.r = {t.r[52:0], 1'b0};
    end
    return t;
  endfunction

  dfr_t fr_r;
  dst_t st_r [0:emfc_pkg::DIV_ITERS];

  always_ff @(posedge clk) begin
    if (adv) begin
      fr_r     <= div_front(num, den);
      st_r[0]  <= div_norm(fr_r);
      for (int k = 1; k <= emfc_pkg::DIV_ITERS; k++) begin
        st_r[k] <= div_step(st_r[k-1]);
      end
    end
  end

  always_comb begin
    quo.cls = st_r[emfc_pkg::DIV_ITERS].cls;
    quo.sgn = st_r[emfc_pkg::DIV_ITERS].sgn;
    quo.ex  = st_r[emfc_pkg::DIV_ITERS].ex;
    quo.mag = {st_r[emfc_pkg::DIV_ITERS].q, 49'd0,
               (st_r[emfc_pkg::DIV_ITERS].r != 54'd0)};
  end

endmodule
`default_nettype wire
